### src/sefe_pkg.sv
// Shared types and constants of the sparse entry flag eliminator.
package sefe_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ENTRY = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_DIMS  = 1'b1;

  localparam logic MODE_DELETE = 1'b0;
  localparam logic MODE_DIAG   = 1'b1;

  localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;
  localparam logic [10:0] CNT_MAX  = 11'd2047;

  // Table word: drop flag on top of the compact id.
  localparam int unsigned TBL_W = 11;

  typedef struct packed {
    req_t        req_type;
    logic [9:0]  row_index;
    logic [9:0]  col_index;
    logic        drop_flag;
    logic [63:0] value_re;
    logic [63:0] value_im;
  } item_t;

  typedef struct packed {
    logic [10:0] kept;
    logic [10:0] loaded;
    logic [10:0] max_col;
  } cnt_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic [63:0] out_value_re;
    logic [63:0] out_value_im;
    logic [10:0] row_count;
    logic [10:0] col_count;
  } res_t;

  typedef struct packed {
    logic             emit;
    logic             tbl_we;
    logic [TBL_W-1:0] tbl_word;
    cnt_t             cnt;
    res_t             res;
  } step_t;

endpackage

### src/sparse_entry_flag_eliminator.sv
// Top level of the sparse entry flag eliminator: input stage, flag table, result register.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser req_type, tdata entry or flag load
//  m_axis   | out | m_axis_tvalid/tready    | tuser result_kind, tdata entry or dims
//  cfg      | in  | cfg_we (no wait)        | cfg_wdata = mode
//
// One word per cycle sustained while m_axis does not stall. A word is registered in the input stage
// while the flag/id table (one write, two registered reads) is read for its row and column, then
// lands in the result register, which drives m_axis_tvalid.
// Reset clears counters, mode and valid flags; the table is not cleared and holds
// garbage until loaded. A stall on m_axis holds the input stage and drops s_axis_tready
// only while the stage holds a word that makes a result.
module sparse_entry_flag_eliminator #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,     // mode
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // req_type
  // row_index[9:0], col_index[19:10], drop_flag[20], value_re[84:21],
  // value_im[148:85], zero pad
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic         m_axis_tuser,  // result_kind
  // out_row[9:0], out_col[19:10], out_value_re[83:20], out_value_im[147:84],
  // row_count[158:148], col_count[169:159], zero pad
  output logic [175:0] m_axis_tdata
);

  // Indices are 10 bits wide, so the table never needs more than 1024 rows.
  localparam int unsigned TBL_DEPTH = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;
  localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);

  logic                       mode;
  logic                       accept;
  logic                       s1_valid;
  logic                       s1_go;
  sefe_pkg::item_t            s1;
  sefe_pkg::item_t            in_item;
  sefe_pkg::cnt_t             cnt;
  sefe_pkg::step_t            step;
  logic [sefe_pkg::TBL_W-1:0] ram_row;
  logic [sefe_pkg::TBL_W-1:0] ram_col;
  logic [sefe_pkg::TBL_W-1:0] row_word;
  logic [sefe_pkg::TBL_W-1:0] col_word;
  logic                       tbl_we;
  logic                       byp_valid;
  logic [ADDR_W-1:0]          byp_addr;
  logic [sefe_pkg::TBL_W-1:0] byp_word;
  logic                       out_valid;
  logic                       out_free;
  sefe_pkg::res_t             out_res;

  assign in_item.req_type  = sefe_pkg::req_t'(s_axis_tuser);
  assign in_item.row_index = s_axis_tdata[9:0];
  assign in_item.col_index = s_axis_tdata[19:10];
  assign in_item.drop_flag = s_axis_tdata[20];
  assign in_item.value_re  = s_axis_tdata[84:21];
  assign in_item.value_im  = s_axis_tdata[148:85];

  // The stage advances unless it has a result and the result register is full.
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_go         = s1_valid && (!step.emit || out_free);
  assign s_axis_tready = !s1_valid || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tbl_we        = s1_go && step.tbl_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sefe_pkg::MODE_DELETE;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Input stage: the table read is issued at the same edge the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
  end

  sefe_ram #(
    .WIDTH (sefe_pkg::TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (s1.row_index[ADDR_W-1:0]),
    .wdata   (step.tbl_word),
    .re      (accept),
    .raddr_a (in_item.row_index[ADDR_W-1:0]),
    .raddr_b (in_item.col_index[ADDR_W-1:0]),
    .rdata_a (ram_row),
    .rdata_b (ram_col)
  );

  // A load retiring on the same edge as the read is not yet in the RAM output:
  // hold the last write and forward it on an address match.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (tbl_we) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      byp_addr <= s1.row_index[ADDR_W-1:0];
      byp_word <= step.tbl_word;
    end
  end

  assign row_word = (byp_valid && byp_addr == s1.row_index[ADDR_W-1:0]) ? byp_word : ram_row;
  assign col_word = (byp_valid && byp_addr == s1.col_index[ADDR_W-1:0]) ? byp_word : ram_col;

  sefe_filter #(
    .MAX_SIZE (MAX_SIZE)
  ) u_filter (
    .mode     (mode),
    .item     (s1),
    .row_word (row_word),
    .col_word (col_word),
    .cnt      (cnt),
    .step     (step)
  );

  // Counters advance only when the word leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (s1_go) begin
      cnt <= step.cnt;
    end
  end

  // Result register: refill on a retiring result, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && step.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step.emit) begin
      out_res <= step.res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.result_kind;
  assign m_axis_tdata  = {6'd0, out_res.col_count, out_res.row_count, out_res.out_value_im,
                          out_res.out_value_re, out_res.out_col, out_res.out_row};

endmodule

### src/sefe_ram.sv
// Generic RAM with one write port and two registered read ports.
module sefe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### src/sefe_filter.sv
// Per-word decision: table bookkeeping for loads, filtering of entries, dimension report.
module sefe_filter #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic                       mode,
  input  sefe_pkg::item_t            item,
  input  logic [sefe_pkg::TBL_W-1:0] row_word,
  input  logic [sefe_pkg::TBL_W-1:0] col_word,
  input  sefe_pkg::cnt_t             cnt,
  output sefe_pkg::step_t            step
);

  logic           row_ok;
  logic           col_ok;
  logic           fr;
  logic           fc;
  logic           note_en;
  logic [9:0]     note_col;
  logic [10:0]    note_n;
  sefe_pkg::cnt_t base;

  assign row_ok = 32'(item.row_index) < 32'(MAX_SIZE);
  assign col_ok = 32'(item.col_index) < 32'(MAX_SIZE);
  assign fr     = row_word[sefe_pkg::TBL_W-1];
  assign fc     = col_word[sefe_pkg::TBL_W-1];
  assign base   = (item.row_index == 10'd0) ? '0 : cnt;
  assign note_n = {1'b0, note_col} + 11'd1;

  always_comb begin
    step     = '0;
    step.cnt = cnt;
    note_en  = 1'b0;
    note_col = '0;
    case (item.req_type)
      sefe_pkg::REQ_LOAD: begin
        if (row_ok) begin
          // index 0 restarts numbering before the flag lands
          step.tbl_we   = 1'b1;
          step.tbl_word = {item.drop_flag, base.kept[9:0]};
          step.cnt      = base;
          if (!item.drop_flag && base.kept != sefe_pkg::CNT_MAX) begin
            step.cnt.kept = base.kept + 11'd1;
          end
          step.cnt.loaded = {1'b0, item.row_index} + 11'd1;
        end
      end
      sefe_pkg::REQ_ENTRY: begin
        if (row_ok && col_ok && ({1'b0, item.row_index} < cnt.loaded)
            && ({1'b0, item.col_index} < cnt.loaded)) begin
          step.res.result_kind  = sefe_pkg::KIND_ENTRY;
          step.res.out_value_re = item.value_re;
          step.res.out_value_im = item.value_im;
          if (mode == sefe_pkg::MODE_DELETE) begin
            if (!fr && !fc) begin
              step.emit        = 1'b1;
              step.res.out_row = row_word[9:0];
              step.res.out_col = col_word[9:0];
              note_en          = 1'b1;
              note_col         = col_word[9:0];
            end
          end else if (fr) begin
            // constrained row keeps only its diagonal, forced to 1.0
            if (item.col_index == item.row_index) begin
              step.emit             = 1'b1;
              step.res.out_row      = item.row_index;
              step.res.out_col      = item.row_index;
              step.res.out_value_re = sefe_pkg::ONE_BITS;
              step.res.out_value_im = '0;
              note_en               = 1'b1;
              note_col              = item.row_index;
            end
          end else if (!fc) begin
            step.emit        = 1'b1;
            step.res.out_row = item.row_index;
            step.res.out_col = item.col_index;
            note_en          = 1'b1;
            note_col         = item.col_index;
          end
        end
      end
      sefe_pkg::REQ_QUERY: begin
        step.emit            = 1'b1;
        step.res.result_kind = sefe_pkg::KIND_DIMS;
        step.res.row_count   = (mode == sefe_pkg::MODE_DIAG) ? cnt.loaded : cnt.kept;
        step.res.col_count   = (cnt.max_col == 11'd0) ? 11'd1 : cnt.max_col;
      end
      default: begin
        step.emit = 1'b0;
      end
    endcase
    if (step.emit && note_en && note_n > cnt.max_col) begin
      step.cnt.max_col = note_n;
    end
  end

endmodule
